@@ sv/prc_pkg.sv @@
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types, codes and helpers for the polyline rectangle cull block.
// ----------------------------------------------------------------------------
`default_nettype none

package prc_pkg;

  localparam int COORD_BITS = 32;
  localparam int COORD_W    = 32;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CFG_IDX_W  = 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  typedef enum logic {
    REQ_MOVE = 1'b0,
    REQ_LINE = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    VERDICT_NONE  = 2'd0,
    VERDICT_CONT  = 2'd1,
    VERDICT_START = 2'd2
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT   = 2'd0,
    CFG_TOP    = 2'd1,
    CFG_RIGHT  = 2'd2,
    CFG_BOTTOM = 2'd3
  } cfg_idx_t;

  // low COORD_BITS bits, sign-extended to the port width
  function automatic coord_t sext_coord(input logic [COORD_W-1:0] v);
    logic signed [COORD_BITS-1:0] t;
    t = v[COORD_BITS-1:0];
    return COORD_W'(t);
  endfunction

  function automatic diff_t sub_coord(input coord_t a, input coord_t b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

endpackage

`default_nettype wire

@@ sv/prc_ifs.sv @@
// ----------------------------------------------------------------------------
// prc_ifs
// Valid/ready channels of the polyline rectangle cull block.
// ----------------------------------------------------------------------------
`default_nettype none

interface prc_req_if import prc_pkg::*;;
  logic      valid;
  logic      ready;
  req_type_t req_type;
  coord_t    point_x;
  coord_t    point_y;

  modport source (output valid, output req_type, output point_x, output point_y,
                  input ready);
  modport sink (input valid, input req_type, input point_x, input point_y,
                output ready);
endinterface

interface prc_res_if import prc_pkg::*;;
  logic     valid;
  logic     ready;
  verdict_t verdict;
  coord_t   start_x;
  coord_t   start_y;
  coord_t   end_x;
  coord_t   end_y;

  modport source (output valid, output verdict, output start_x, output start_y,
                  output end_x, output end_y, input ready);
  modport sink (input valid, input verdict, input start_x, input start_y,
                input end_x, input end_y, output ready);
endinterface

interface prc_cfg_if import prc_pkg::*;;
  logic                      valid;
  logic                      ready;
  cfg_idx_t                  index;
  logic signed [COORD_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/polyline_rect_cull_top.sv @@
// ----------------------------------------------------------------------------
// polyline_rect_cull_top
// Culls a stream of polyline vertices against a configured rectangle.
// ----------------------------------------------------------------------------
// One result beat comes out for every request beat, in order, unless a config
// write meets a move of the result register. The block takes one vertex per
// cycle while req.ready is high, through the input register, difference stage,
// product stage and result register; the product stage holds four 33 x 33 bit
// signed multipliers that form the exact cross products against the rectangle
// corners. A stall on the result side fills the empty stages first and only
// then holds the request side. A configuration write lands at once, and also
// clears the previous point to the origin and restarts the polyline.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_rect_cull_top import prc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  prc_req_if.sink    req,
  prc_res_if.source  res,
  prc_cfg_if.sink    cfg
);

  coord_t rect_left, rect_top, rect_right, rect_bottom;
  coord_t last_x, last_y;
  logic   last_drawn;

  logic en1, en2, en3, en_o;

  // stage 1: input register
  logic      s1_valid;
  req_type_t s1_type;
  coord_t    s1_x0, s1_y0, s1_x1, s1_y1;

  // stage 2: differences and edge tests
  logic      s2_valid;
  req_type_t s2_type;
  coord_t    s2_x0, s2_y0, s2_x1, s2_y1;
  logic      s2_reject, s2_inside;
  diff_t     s2_vx, s2_vy, s2_dxl, s2_dxr, s2_dyt, s2_dyb;

  // stage 3: cross products
  logic      s3_valid;
  req_type_t s3_type;
  coord_t    s3_x0, s3_y0, s3_x1, s3_y1;
  logic      s3_reject, s3_inside;
  prod_t     s3_pt, s3_pb, s3_pl, s3_pr;

  // result register
  logic      out_valid;
  verdict_t  out_verdict;
  coord_t    out_start_x, out_start_y, out_end_x, out_end_y;

  logic      reject_c, inside_c;
  logic      side0, side1, side2, side3, corner_hit, hit;
  verdict_t  verdict_c;
  logic      cfg_write;

  assign en_o = !out_valid || res.ready;
  assign en3  = !s3_valid || en_o;
  assign en2  = !s2_valid || en3;
  assign en1  = !s1_valid || en2;

  assign req.ready = en1;
  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid;

  // configuration and previous point
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_left   <= '0;
      rect_top    <= '0;
      rect_right  <= '0;
      rect_bottom <= '0;
      last_x      <= '0;
      last_y      <= '0;
    end else if (cfg_write) begin
      case (cfg.index)
        CFG_LEFT:   rect_left   <= sext_coord(cfg.data);
        CFG_TOP:    rect_top    <= sext_coord(cfg.data);
        CFG_RIGHT:  rect_right  <= sext_coord(cfg.data);
        CFG_BOTTOM: rect_bottom <= sext_coord(cfg.data);
        default:    rect_left   <= rect_left;
      endcase
      last_x <= '0;
      last_y <= '0;
    end else if (req.valid && en1) begin
      last_x <= sext_coord(req.point_x);
      last_y <= sext_coord(req.point_y);
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_type <= req.req_type;
      s1_x0   <= last_x;
      s1_y0   <= last_y;
      s1_x1   <= sext_coord(req.point_x);
      s1_y1   <= sext_coord(req.point_y);
    end
  end

  // stage 2
  always_comb begin
    reject_c = (s1_x0 < rect_left   && s1_x1 < rect_left)   ||
               (s1_x0 > rect_right  && s1_x1 > rect_right)  ||
               (s1_y0 < rect_top    && s1_y1 < rect_top)    ||
               (s1_y0 > rect_bottom && s1_y1 > rect_bottom);
    inside_c = (s1_x0 >= rect_left && s1_x0 < rect_right &&
                s1_y0 >= rect_top  && s1_y0 < rect_bottom) ||
               (s1_x1 >= rect_left && s1_x1 < rect_right &&
                s1_y1 >= rect_top  && s1_y1 < rect_bottom);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_type   <= s1_type;
      s2_x0     <= s1_x0;
      s2_y0     <= s1_y0;
      s2_x1     <= s1_x1;
      s2_y1     <= s1_y1;
      s2_reject <= reject_c;
      s2_inside <= inside_c;
      s2_vx     <= sub_coord(s1_x1, s1_x0);
      s2_vy     <= sub_coord(s1_y1, s1_y0);
      s2_dxl    <= sub_coord(s1_x0, rect_left);
      s2_dxr    <= sub_coord(s1_x0, rect_right);
      s2_dyt    <= sub_coord(s1_y0, rect_top);
      s2_dyb    <= sub_coord(s1_y0, rect_bottom);
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_type   <= s2_type;
      s3_x0     <= s2_x0;
      s3_y0     <= s2_y0;
      s3_x1     <= s2_x1;
      s3_y1     <= s2_y1;
      s3_reject <= s2_reject;
      s3_inside <= s2_inside;
      s3_pt     <= PROD_W'(s2_vx) * PROD_W'(s2_dyt);
      s3_pb     <= PROD_W'(s2_vx) * PROD_W'(s2_dyb);
      s3_pl     <= PROD_W'(s2_dxl) * PROD_W'(s2_vy);
      s3_pr     <= PROD_W'(s2_dxr) * PROD_W'(s2_vy);
    end
  end

  // corner sides and verdict
  always_comb begin
    side0      = s3_pt < s3_pl;
    side1      = s3_pt < s3_pr;
    side2      = s3_pb < s3_pr;
    side3      = s3_pb < s3_pl;
    corner_hit = (side1 != side0) || (side2 != side0) || (side3 != side0);
    hit        = (s3_type == REQ_LINE) && !s3_reject && (s3_inside || corner_hit);
    if (!hit) begin
      verdict_c = VERDICT_NONE;
    end else if (last_drawn) begin
      verdict_c = VERDICT_CONT;
    end else begin
      verdict_c = VERDICT_START;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      last_drawn <= 1'b0;
    end else if (cfg_write) begin
      last_drawn <= 1'b0;
    end else if (en_o) begin
      out_valid <= s3_valid;
      if (s3_valid) begin
        last_drawn <= hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      out_verdict <= verdict_c;
      out_start_x <= hit ? s3_x0 : '0;
      out_start_y <= hit ? s3_y0 : '0;
      out_end_x   <= hit ? s3_x1 : '0;
      out_end_y   <= hit ? s3_y1 : '0;
    end
  end

  assign res.valid   = out_valid;
  assign res.verdict = out_verdict;
  assign res.start_x = out_start_x;
  assign res.start_y = out_start_y;
  assign res.end_x   = out_end_x;
  assign res.end_y   = out_end_y;

endmodule

`default_nettype wire

@@ sv/prc_checker.sv @@
// ----------------------------------------------------------------------------
// prc_checker
// Port-level checks for the polyline rectangle cull block.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_checker import prc_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     req_valid,
  input wire logic     req_ready,
  input wire logic     res_valid,
  input wire logic     res_ready,
  input wire verdict_t res_verdict,
  input wire coord_t   res_start_x,
  input wire coord_t   res_start_y,
  input wire coord_t   res_end_x,
  input wire coord_t   res_end_y
);

  logic       req_beat, res_beat;
  logic [3:0] pending;
  logic       prev_drawn;
  coord_t     prev_end_x, prev_end_y;

  assign req_beat = req_valid && req_ready;
  assign res_beat = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(req_beat) - 4'(res_beat);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_drawn <= 1'b0;
    end else if (res_beat) begin
      prev_drawn <= res_verdict != VERDICT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (res_beat) begin
      prev_end_x <= res_end_x;
      prev_end_y <= res_end_y;
    end
  end

  // no result beat without an outstanding request
  assert property (@(posedge clk) disable iff (rst) res_beat |-> pending != 4'd0)
    else $error("result beat without pending request");

  // culled or move results carry zero coordinates
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_verdict == VERDICT_NONE |->
      res_start_x == '0 && res_start_y == '0 && res_end_x == '0 && res_end_y == '0)
    else $error("empty verdict with nonzero coordinates");

  // a continuation picks up where the last drawn segment ended
  assert property (@(posedge clk) disable iff (rst)
    res_beat && res_verdict == VERDICT_CONT |->
      prev_drawn && res_start_x == prev_end_x && res_start_y == prev_end_y)
    else $error("continuation does not join previous segment");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=>
      res_valid && $stable(res_verdict) && $stable(res_end_x) && $stable(res_end_y))
    else $error("stalled result changed");

endmodule

bind polyline_rect_cull_top prc_checker u_prc_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_verdict (res.verdict),
  .res_start_x (res.start_x),
  .res_start_y (res.start_y),
  .res_end_x   (res.end_x),
  .res_end_y   (res.end_y)
);

`default_nettype wire
